// ----- hw/rtl/lisqrt_pkg.sv -----
// lisqrt_pkg: shared widths, types and the square-root table entry function
// for the interpolated integer square root block. No dependencies.
package lisqrt_pkg;

    localparam int RADICAND_W = 32;
    localparam int ROOT_W     = 32;
    localparam int ROOT_FRAC  = 16;
    localparam int NORM_W     = RADICAND_W + 1;
    localparam int LZ_W       = 5;
    localparam int SHIFT_W    = 6;
    localparam int HALF_W     = 5;
    localparam int SQ_GUARD   = 27;

    typedef logic [RADICAND_W-1:0] t_radicand;
    typedef logic [ROOT_W-1:0]     t_root;
    typedef logic [63:0]           t_wide;

    // Table entry for n = 2^(addr_bits-2) + i: sqrt(n / 2^(addr_bits-1)) rounded
    // to single precision, then truncated to value_bits fraction bits.
    function automatic t_wide lut_entry(input int unsigned n, input int unsigned addr_bits,
                                        input int unsigned value_bits);
        t_wide       v;
        t_wide       res;
        t_wide       b;
        t_wide       up;
        t_wide       m;
        int unsigned drop;
        v   = t_wide'(n) << (2 * SQ_GUARD + 1 - addr_bits);
        res = '0;
        b   = t_wide'(1) << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        drop = (res >= (t_wide'(1) << SQ_GUARD)) ? 4 : 3;
        up   = (res >> (drop - 1)) & t_wide'(1);
        m    = ((res >> drop) + up) << drop;
        return m >> (SQ_GUARD - value_bits);
    endfunction

endpackage

// ----- hw/rtl/lisqrt_norm.sv -----
// lisqrt_norm: leading-zero count, odd-width normalization, table address,
// interpolation fraction and output shift, registered. Uses lisqrt_pkg.
module lisqrt_norm #(
    parameter int TABLE_ADDR_BITS  = 8,
    parameter int INTERP_FRAC_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  lisqrt_pkg::t_radicand           i_radicand,
    output logic [TABLE_ADDR_BITS-1:0]      o_addr,
    output logic [INTERP_FRAC_BITS-1:0]     o_frac,
    output logic [lisqrt_pkg::HALF_W-1:0]   o_half,
    output logic                            o_zero
);

    localparam logic [TABLE_ADDR_BITS-1:0] LUT_OFFSET =
        TABLE_ADDR_BITS'(1 << (TABLE_ADDR_BITS - 2));
    localparam logic [TABLE_ADDR_BITS-1:0] LUT_LAST =
        TABLE_ADDR_BITS'((1 << TABLE_ADDR_BITS) - (1 << (TABLE_ADDR_BITS - 2)));
    localparam logic [TABLE_ADDR_BITS-1:0] LUT_CLAMP = LUT_LAST - TABLE_ADDR_BITS'(1);

    logic [lisqrt_pkg::LZ_W-1:0]    lz;
    logic [lisqrt_pkg::SHIFT_W-1:0] shamt;
    logic [lisqrt_pkg::NORM_W-1:0]  norm;
    logic [TABLE_ADDR_BITS-1:0]     addr_raw;
    logic [TABLE_ADDR_BITS-1:0]     n_addr;

    always_comb begin
        lz = '0;
        for (int k = 0; k < lisqrt_pkg::RADICAND_W; k++) begin
            if (i_radicand[k]) begin
                lz = lisqrt_pkg::LZ_W'(lisqrt_pkg::RADICAND_W - 1 - k);
            end
        end
        // round the shift up to even so the significant width is odd
        shamt    = {1'b0, lz} + {{(lisqrt_pkg::SHIFT_W-1){1'b0}}, lz[0]};
        norm     = {1'b0, i_radicand} << shamt;
        addr_raw = norm[lisqrt_pkg::NORM_W-1 -: TABLE_ADDR_BITS];
        n_addr   = (addr_raw >= LUT_OFFSET) ? addr_raw - LUT_OFFSET : '0;
        if (n_addr >= LUT_LAST) begin
            n_addr = LUT_CLAMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_addr <= n_addr;
            o_frac <= norm[lisqrt_pkg::NORM_W-1-TABLE_ADDR_BITS -: INTERP_FRAC_BITS];
            o_half <= lisqrt_pkg::HALF_W'(16) - shamt[lisqrt_pkg::SHIFT_W-1:1];
            o_zero <= (i_radicand == '0);
        end
    end

endmodule

// ----- hw/rtl/lisqrt_rom.sv -----
// lisqrt_rom: constant square-root table with two synchronous read ports
// (entry and its successor). Uses lisqrt_pkg::lut_entry.
module lisqrt_rom #(
    parameter int TABLE_ADDR_BITS  = 8,
    parameter int TABLE_VALUE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [TABLE_ADDR_BITS-1:0]    i_addr,
    output logic [TABLE_VALUE_BITS:0]     o_lo,
    output logic [TABLE_VALUE_BITS:0]     o_hi
);

    localparam int LUT_OFFSET = 1 << (TABLE_ADDR_BITS - 2);
    localparam int LUT_LEN    = (1 << TABLE_ADDR_BITS) - LUT_OFFSET + 1;

    logic [TABLE_VALUE_BITS:0] rom [LUT_LEN];

    for (genvar g = 0; g < LUT_LEN; g++) begin : g_rom
        localparam lisqrt_pkg::t_wide ENTRY =
            lisqrt_pkg::lut_entry(g + LUT_OFFSET, TABLE_ADDR_BITS, TABLE_VALUE_BITS);
        assign rom[g] = ENTRY[TABLE_VALUE_BITS:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lo <= rom[i_addr];
            o_hi <= rom[i_addr + TABLE_ADDR_BITS'(1)];
        end
    end

endmodule

// ----- hw/rtl/lisqrt_interp.sv -----
// lisqrt_interp: weighted products of two table entries, then sum, scale,
// saturate and zero override into the result register. Uses lisqrt_pkg.
module lisqrt_interp #(
    parameter int TABLE_VALUE_BITS = 16,
    parameter int INTERP_FRAC_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_en_mul,
    input  logic                            i_en_out,
    input  logic [TABLE_VALUE_BITS:0]       i_lo,
    input  logic [TABLE_VALUE_BITS:0]       i_hi,
    input  logic [INTERP_FRAC_BITS-1:0]     i_frac,
    input  logic [lisqrt_pkg::HALF_W-1:0]   i_half,
    input  logic                            i_zero,
    output lisqrt_pkg::t_root               o_root
);

    localparam int PROD_W = TABLE_VALUE_BITS + INTERP_FRAC_BITS + 2;
    localparam int MIX_W  = (PROD_W + 16 > INTERP_FRAC_BITS + 33) ?
                            PROD_W + 16 : INTERP_FRAC_BITS + 33;

    logic [INTERP_FRAC_BITS:0]            w_lo;
    logic [PROD_W-1:0]                    r_p_lo;
    logic [PROD_W-1:0]                    r_p_hi;
    logic [lisqrt_pkg::HALF_W-1:0]        r_half;
    logic                                 r_zero;
    logic [PROD_W-1:0]                    sum;
    logic [MIX_W-1:0]                     mix;
    lisqrt_pkg::t_root                    n_root;

    assign w_lo = {1'b1, {INTERP_FRAC_BITS{1'b0}}} - {1'b0, i_frac};

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_p_lo <= PROD_W'(i_lo) * PROD_W'(w_lo);
            r_p_hi <= PROD_W'(i_hi) * PROD_W'(i_frac);
            r_half <= i_half;
            r_zero <= i_zero;
        end
    end

    always_comb begin
        sum = r_p_lo + r_p_hi;
        mix = (MIX_W'(sum) << r_half) >> INTERP_FRAC_BITS;
        if (r_zero) begin
            n_root = '0;
        end else if (|mix[MIX_W-1:lisqrt_pkg::ROOT_W]) begin
            n_root = '1;
        end else begin
            n_root = mix[lisqrt_pkg::ROOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            o_root <= n_root;
        end
    end

endmodule

// ----- hw/rtl/lut_interp_integer_sqrt_top.sv -----
// lut_interp_integer_sqrt_top: top level, four-stage pipeline with per-stage
// valid/stall control. Uses lisqrt_pkg, lisqrt_norm, lisqrt_rom, lisqrt_interp.
//
// Returns the square root of a 32-bit unsigned radicand as a 32-bit unsigned
// value with 16 fraction bits, saturated to all ones; a zero radicand gives 0.
// One request is taken per clock while o_ready is high; each request passes through
// normalize, table read from the dual-port constant ROM, multiply, and sum and
// scale into the output register, where its result is presented. Each stage
// holds only while the one after it is full and stalled, so input keeps flowing
// into empty slots while a result waits at the output.
// The ROM contents are computed when the design is elaborated; there is no
// start-up fill.
module lut_interp_integer_sqrt_top #(
    parameter int TABLE_ADDR_BITS  = 8,
    parameter int TABLE_VALUE_BITS = 16,
    parameter int INTERP_FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  lisqrt_pkg::t_radicand i_radicand,
    output logic                  o_valid,
    input  logic                  i_ready,
    output lisqrt_pkg::t_root     o_root
);

    logic                            r_v1, r_v2, r_v3, r_v4;
    logic                            en1, en2, en3, en4;
    logic [TABLE_ADDR_BITS-1:0]      addr1;
    logic [INTERP_FRAC_BITS-1:0]     frac1;
    logic [lisqrt_pkg::HALF_W-1:0]   half1;
    logic                            zero1;
    logic [INTERP_FRAC_BITS-1:0]     r_frac2;
    logic [lisqrt_pkg::HALF_W-1:0]   r_half2;
    logic                            r_zero2;
    logic [TABLE_VALUE_BITS:0]       lo2, hi2;

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    lisqrt_norm #(
        .TABLE_ADDR_BITS  (TABLE_ADDR_BITS),
        .INTERP_FRAC_BITS (INTERP_FRAC_BITS)
    ) u_norm (
        .i_clk      (i_clk),
        .i_en       (en1),
        .i_radicand (i_radicand),
        .o_addr     (addr1),
        .o_frac     (frac1),
        .o_half     (half1),
        .o_zero     (zero1)
    );

    lisqrt_rom #(
        .TABLE_ADDR_BITS  (TABLE_ADDR_BITS),
        .TABLE_VALUE_BITS (TABLE_VALUE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (en2),
        .i_addr (addr1),
        .o_lo   (lo2),
        .o_hi   (hi2)
    );

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_frac2 <= frac1;
            r_half2 <= half1;
            r_zero2 <= zero1;
        end
    end

    lisqrt_interp #(
        .TABLE_VALUE_BITS (TABLE_VALUE_BITS),
        .INTERP_FRAC_BITS (INTERP_FRAC_BITS)
    ) u_interp (
        .i_clk    (i_clk),
        .i_en_mul (en3),
        .i_en_out (en4),
        .i_lo     (lo2),
        .i_hi     (hi2),
        .i_frac   (r_frac2),
        .i_half   (r_half2),
        .i_zero   (r_zero2),
        .o_root   (o_root)
    );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking bench for lut_interp_integer_sqrt_top; a scoreboard class predicts
// each root from its own square-root table. Depends on lisqrt_pkg and the top level.
module tb;

    typedef lisqrt_pkg::t_radicand t_radicand;
    typedef lisqrt_pkg::t_root     t_root;
    typedef lisqrt_pkg::t_wide     t_wide;

    localparam int ADDR_BITS   = 8;
    localparam int VALUE_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int TABLE_BASE  = 1 << (ADDR_BITS - 2);
    localparam int TABLE_LEN   = (1 << ADDR_BITS) - TABLE_BASE + 1;
    localparam int SQRT_GUARD  = 27;
    localparam int CLK_HALF    = 6;
    localparam int RESET_CYC   = 6;
    localparam int PIPE_CYC    = 8;
    localparam int LONG_HOLD   = 80;
    localparam int TOTAL_ITEMS = 550;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_valid    = 1'b0;
    logic      o_ready;
    t_radicand i_radicand = '0;
    logic      o_valid;
    logic      i_ready    = 1'b0;
    t_root     o_root;

    int holds_asked = 0;
    int n_input_stalls = 0;
    int n_zero = 0;

    always #CLK_HALF i_clk = ~i_clk;

    lut_interp_integer_sqrt_top #(
        .TABLE_ADDR_BITS (ADDR_BITS),
        .TABLE_VALUE_BITS(VALUE_BITS),
        .INTERP_FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_radicand(i_radicand),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_root    (o_root)
    );

    typedef struct {
        t_radicand radicand;
        t_root     root;
    } t_root_expect;

    class sqrt_scoreboard;
        t_wide        root_table[TABLE_LEN];
        t_root_expect expected_roots[$];
        int           n_requests;
        int           n_results;
        int           n_errors;

        function new();
            for (int i = 0; i < TABLE_LEN; i++) begin
                root_table[i] = table_entry(i);
            end
            n_requests = 0;
            n_results  = 0;
            n_errors   = 0;
        endfunction

        function t_wide int_sqrt(t_wide val);
            t_wide rem;
            t_wide acc;
            t_wide place;
            rem   = val;
            acc   = '0;
            place = t_wide'(1) << 62;
            while (place > rem) place = place >> 2;
            while (place != 0) begin
                if (rem >= acc + place) begin
                    rem = rem - (acc + place);
                    acc = (acc >> 1) + place;
                end else begin
                    acc = acc >> 1;
                end
                place = place >> 2;
            end
            return acc;
        endfunction

        // sqrt of (BASE+idx)/2^(A-1), rounded to single precision, truncated
        function t_wide table_entry(int idx);
            t_wide q;
            int    drop;
            q    = int_sqrt(t_wide'(TABLE_BASE + idx) << (2 * SQRT_GUARD + 1 - ADDR_BITS));
            drop = (q >= (t_wide'(1) << SQRT_GUARD)) ? 4 : 3;
            q    = ((q >> drop) + ((q >> (drop - 1)) & t_wide'(1))) << drop;
            return q >> (SQRT_GUARD - VALUE_BITS);
        endfunction

        function t_root predict_root(t_radicand rad);
            int    lz;
            int    nbits;
            t_wide s;
            t_wide addr;
            t_wide frac;
            t_wide lo;
            t_wide hi;
            t_wide mix;
            if (rad == '0) return '0;
            s  = t_wide'(rad);
            lz = 0;
            while (lz < 32 && rad[31-lz] == 1'b0) lz++;
            nbits = (lz % 2 == 1) ? 32 - lz : 33 - lz;
            if (nbits > ADDR_BITS) addr = s >> (nbits - ADDR_BITS);
            else addr = s << (ADDR_BITS - nbits);
            addr = (addr >= TABLE_BASE) ? addr - TABLE_BASE : '0;
            if (addr + 1 >= TABLE_LEN) addr = t_wide'(TABLE_LEN - 2);
            if (nbits >= ADDR_BITS + FRAC_BITS)
                frac = (s >> (nbits - ADDR_BITS - FRAC_BITS)) & ((t_wide'(1) << FRAC_BITS) - 1);
            else if (nbits >= ADDR_BITS)
                frac = (s << (ADDR_BITS + FRAC_BITS - nbits)) & ((t_wide'(1) << FRAC_BITS) - 1);
            else
                frac = '0;
            lo  = root_table[int'(addr)] << (nbits / 2);
            hi  = root_table[int'(addr) + 1] << (nbits / 2);
            mix = (lo * ((t_wide'(1) << FRAC_BITS) - frac) + hi * frac) >> FRAC_BITS;
            return (mix > t_wide'(32'hFFFF_FFFF)) ? '1 : mix[31:0];
        endfunction

        task report_mismatch(string msg);
            n_errors++;
            $display("[%0t] ERROR: %s", $realtime, msg);
        endtask

        function void note_request(t_radicand rad);
            t_root_expect e;
            e.radicand = rad;
            e.root     = predict_root(rad);
            expected_roots.push_back(e);
            n_requests++;
        endfunction

        task check_root(t_root got);
            t_root_expect e;
            n_results++;
            if (expected_roots.size() == 0) begin
                report_mismatch($sformatf("root %h with no request pending", got));
            end else begin
                e = expected_roots.pop_front();
                if (got !== e.root)
                    report_mismatch($sformatf("radicand %h: root %h, want %h",
                                              e.radicand, got, e.root));
            end
        endtask

        function int pending();
            return expected_roots.size();
        endfunction
    endclass

    sqrt_scoreboard sb = new();

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_request(i_radicand);
            if (i_radicand == '0) n_zero++;
        end
        if (i_rst_n && i_valid && !o_ready) n_input_stalls++;
        if (i_rst_n && o_valid && i_ready) sb.check_root(o_root);
    end

    // output side: shifting stall modes, plus long hold-offs on demand
    initial begin
        int holds_done;
        int hold_left;
        int mode;
        int mode_left;
        int tick;
        holds_done = 0;
        hold_left  = 0;
        mode       = 0;
        mode_left  = 0;
        tick       = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (holds_asked != holds_done) begin
                holds_done = holds_asked;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= ($urandom_range(0, 9) != 0);
                    default: i_ready <= (tick % 5 != 4);
                endcase
            end
        end
    end

    initial begin
        #2_400_000;
        $display("timeout: %0d results still pending", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task send_radicand(t_radicand rad);
        i_valid    <= 1'b1;
        i_radicand <= rad;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task idle_input(int cycles);
        if (cycles > 0) begin
            i_valid    <= 1'b0;
            i_radicand <= $urandom;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task wait_all_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function t_radicand pick_radicand();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return $urandom_range(0, 300);
            3: return (32'h1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
            4: return ~($urandom >> $urandom_range(8, 31));
            default: return {$urandom_range(0, 1) ? 8'hFF : 8'h01, 24'($urandom)};
        endcase
    endfunction

    t_radicand directed_set[] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004,
        32'h0000_007F, 32'h0000_0080, 32'h0000_00FF, 32'h0000_0100, 32'h0000_8000,
        32'h0000_FFFF, 32'h0001_0000, 32'h0001_FFFF, 32'h00FF_FFFF, 32'h0100_0000,
        32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
        32'h5555_5555, 32'h1234_5678, 32'hFFFF_FFFE, 32'hFFFF_FFFF
    };

    initial begin
        int sent;
        int burst;
        int next_drain;
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_set[k]) begin
            send_radicand(directed_set[k]);
            idle_input($urandom_range(0, 2));
        end
        wait_all_results();
        sent = directed_set.size();

        // output held off while requests keep coming: fills the pipe
        holds_asked <= holds_asked + 1;
        repeat (30) send_radicand(pick_radicand());
        sent += 30;

        next_drain = sent + 150;
        while (sent < TOTAL_ITEMS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) send_radicand(pick_radicand());
            sent += burst;
            if (sent >= next_drain) begin
                wait_all_results();
                next_drain += 150;
                if ($urandom_range(0, 1)) holds_asked <= holds_asked + 1;
            end else begin
                idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            end
        end

        wait_all_results();
        repeat (PIPE_CYC) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d roots never returned", sb.pending()));
        $display("Covered %0d radicands (%0d zero, edges of every octave), %0d roots checked,",
                 sb.n_requests, n_zero, sb.n_results);
        $display("with bursty input, shifting output stalls and %0d stalled request cycles.",
                 n_input_stalls);
        if (sb.n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
